[rtl/core/dq_pkg.sv]
// Package for the double-ended queue: depth, widths, request and status codes,
// and the control word that the top level sends to every storage cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 5;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // One operation at most is set in a given cycle.
    typedef struct packed {
        logic shift_r;   // push front: every entry moves one cell toward the rear
        logic shift_l;   // pop front: every entry moves one cell toward the front
        logic push_rear; // the first empty cell takes the new item
        logic pop_rear;  // the last occupied cell empties
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/core/dq_cell.sv]
// One storage cell of the double-ended queue: a data word and its valid bit.
// It takes data from either neighbor on shifts. Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  dq_pkg::t_cell_ctrl     i_ctrl,
    input  wire  [dq_pkg::DATA_W-1:0]    i_value,
    input  wire  [dq_pkg::DATA_W-1:0]    i_left_data,
    input  wire                          i_left_valid,
    input  wire  [dq_pkg::DATA_W-1:0]    i_right_data,
    input  wire                          i_right_valid,
    output logic [dq_pkg::DATA_W-1:0]    o_data,
    output logic                         o_valid,
    output logic                         o_tail
);
    import dq_pkg::*;

    logic [DATA_W-1:0] r_data, n_data;
    logic              r_valid, n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        priority if (i_ctrl.shift_r) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.shift_l) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.push_rear) begin
            if (i_left_valid && !r_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.pop_rear) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_tail  = r_valid && !i_right_valid;

endmodule

`default_nettype wire

[rtl/core/double_ended_queue.sv]
// Top level of the double-ended queue: a row of dq_cell instances with the front
// entry in cell 0, plus request decode, entry count and result registers.
// Depends on dq_pkg and dq_cell.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy is
//   always low, so a request can be issued in every cycle. i_kind selects push
//   front, push rear, pop front or pop rear; i_item_value is the value pushed.
//   Every request gives exactly one result, shown for one cycle with o_valid
//   high in the cycle after the request: the popped value (zero on pushes and
//   on errors), the status (ok, pop while empty, push while full) and the entry
//   count after the request.
//   Throughput is one request per cycle. Each request updates the cell row, and
//   the result registers take the outcome at the same edge as the cells.
//   Pushes into a full queue and pops from an empty queue change nothing.
//   Results cannot be held off by the receiver, so nothing waits inside.
//   Reset (synchronous, active low) empties the queue and drops any pending
//   result; the stored data words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [1:0]                    i_kind,
    input  wire signed [dq_pkg::DATA_W-1:0] i_item_value,
    output logic                          o_valid,
    output logic signed [dq_pkg::DATA_W-1:0] o_popped_value,
    output logic [1:0]                    o_status,
    output logic [dq_pkg::ENTRY_W-1:0]    o_entry_count
);
    import dq_pkg::*;

    logic [DATA_W-1:0] w_data  [DEPTH];
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_tail;
    logic [DATA_W-1:0] w_tail_data;

    t_kind      w_kind;
    t_cell_ctrl w_ctrl;
    logic       w_accept, w_full, w_empty, w_push, w_pop;

    logic              r_valid, n_valid;
    logic [DATA_W-1:0] r_popped, n_popped;
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_kind   = t_kind'(i_kind);
    assign w_full   = w_valid[DEPTH-1];
    assign w_empty  = !w_valid[0];
    assign w_push   = (w_kind == KIND_PUSH_FRONT) || (w_kind == KIND_PUSH_REAR);
    assign w_pop    = !w_push;

    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            unique case (w_kind)
                KIND_PUSH_FRONT: w_ctrl.shift_r   = !w_full;
                KIND_PUSH_REAR:  w_ctrl.push_rear = !w_full;
                KIND_POP_FRONT:  w_ctrl.shift_l   = !w_empty;
                KIND_POP_REAR:   w_ctrl.pop_rear  = !w_empty;
                default:         w_ctrl = '0;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left_data, w_right_data;
        logic              w_left_valid, w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_data  = i_item_value;
            assign w_left_valid = 1'b1;
        end else begin : g_inner_l
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_r
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_value       (i_item_value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_tail        (w_tail[g])
        );
    end

    // At most one cell is the tail, so an AND-OR picks its word.
    always_comb begin
        w_tail_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_data = w_tail_data | (w_data[i] & {DATA_W{w_tail[i]}});
        end
    end

    always_comb begin
        n_valid  = w_accept;
        n_popped = '0;
        n_status = STATUS_OK;
        n_cnt    = r_cnt;
        if (w_accept) begin
            if (w_push && w_full) begin
                n_status = STATUS_FULL;
            end else if (w_pop && w_empty) begin
                n_status = STATUS_EMPTY;
            end else if (w_push) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_cnt    = r_cnt - CNT_W'(1);
                n_popped = (w_kind == KIND_POP_FRONT) ? w_data[0] : w_tail_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    assign o_valid        = r_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = ENTRY_W'(r_cnt);

`ifndef SYNTHESIS
    a_count_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) == !w_valid[0])
        else $error("entry count and empty cell row disagree");

    a_count_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(DEPTH)) == w_valid[DEPTH-1])
        else $error("entry count and full cell row disagree");

    a_packed_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[DEPTH-1:1] & ~w_valid[DEPTH-2:0]) == '0)
        else $error("occupied cells are not packed toward the front");

    a_one_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted item gave no result");

    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |-> (o_popped_value == '0))
        else $error("failed request returned a nonzero value");
`endif

endmodule

`default_nettype wire

[tb/sv/double_ended_queue_test.sv]
// Self-checking testbench for double_ended_queue: pushes and pops at both ends,
// checks every result against a predictor with its own ring store and count.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module double_ended_queue_test;
    import dq_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int IDX_W       = $clog2(DEPTH);

    typedef struct {
        logic [DATA_W-1:0]  popped;
        t_status            status;
        logic [ENTRY_W-1:0] count;
    } deque_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               i_kind = KIND_PUSH_FRONT;
    logic signed [DATA_W-1:0] i_item_value = '0;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [1:0]               o_status;
    logic [ENTRY_W-1:0]       o_entry_count;

    // Predictor state: ring of slots, front index and number of entries.
    logic [DATA_W-1:0] ring_slots [DEPTH];
    logic [IDX_W-1:0]  front_idx = '0;
    int unsigned       entries = 0;

    deque_result_t pending_results [$];
    int unsigned   accepted_items = 0;
    int unsigned   error_count = 0;
    int unsigned   sender_idle_pct = 0;
    int unsigned   n_pushes = 0, n_pops = 0, n_full = 0, n_empty = 0;

    double_ended_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_item_value   (i_item_value),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic deque_result_t predict_deque_op(t_kind kind, logic [DATA_W-1:0] value);
        deque_result_t r;
        r.popped = '0;
        r.status = STATUS_OK;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                if (entries >= DEPTH) begin
                    r.status = STATUS_FULL;
                    n_full++;
                end else begin
                    if (kind == KIND_PUSH_FRONT) begin
                        front_idx = IDX_W'((front_idx + DEPTH - 1) % DEPTH);
                        ring_slots[front_idx] = value;
                    end else begin
                        ring_slots[(front_idx + entries) % DEPTH] = value;
                    end
                    entries++;
                    n_pushes++;
                end
            end
            default: begin
                if (entries == 0) begin
                    r.status = STATUS_EMPTY;
                    n_empty++;
                end else begin
                    if (kind == KIND_POP_FRONT) begin
                        r.popped = ring_slots[front_idx];
                        front_idx = IDX_W'((front_idx + 1) % DEPTH);
                    end else begin
                        r.popped = ring_slots[(front_idx + entries - 1) % DEPTH];
                    end
                    entries--;
                    n_pops++;
                end
            end
        endcase
        r.count = ENTRY_W'(entries);
        return r;
    endfunction

    // Outputs are checked first, then a request taken at this edge is predicted.
    always @(posedge i_clk) begin
        deque_result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: value %0h status %0d count %0d",
                       o_popped_value, o_status, o_entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_popped_value !== want.popped) begin
                    $error("popped_value: expected %0h, got %0h", want.popped, o_popped_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    error_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_results.push_back(predict_deque_op(t_kind'(i_kind), i_item_value));
            accepted_items++;
        end
    end

    task automatic send_item(t_kind kind, logic [DATA_W-1:0] value);
        int unsigned seen;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_kind       <= kind;
        i_item_value <= value;
        seen = accepted_items;
        wait (accepted_items != seen);
    endtask

    // Hold requests back until every outstanding result has come out.
    task automatic wait_for_drain();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_pops();
        send_item(KIND_POP_FRONT, 32'h1234_5678);
        send_item(KIND_POP_REAR, 32'hffff_ffff);
    endtask

    // Extreme values at both ends; the first front push wraps the index below zero.
    task automatic test_both_ends();
        send_item(KIND_PUSH_FRONT, 32'h8000_0000);
        send_item(KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_item(KIND_PUSH_REAR, 32'h0000_0000);
        send_item(KIND_PUSH_REAR, 32'hffff_ffff);
        send_item(KIND_POP_FRONT, 32'h0);
        send_item(KIND_POP_REAR, 32'h0);
        send_item(KIND_POP_REAR, 32'h0);
        send_item(KIND_POP_FRONT, 32'h0);
        send_item(KIND_POP_FRONT, 32'h0);
    endtask

    // Bursts that lean toward pushes or toward pops, so the queue keeps
    // filling up and running dry, with pushes rejected when full.
    task automatic test_random_bursts(int unsigned idle_pct, int unsigned n_items);
        int unsigned sent;
        int unsigned burst_len;
        int unsigned push_bias;
        t_kind       kind;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < n_items) begin
            burst_len = $urandom_range(40, 8);
            push_bias = ($urandom_range(1)) ? $urandom_range(90, 70) : $urandom_range(30, 10);
            if ($urandom_range(5) == 0)
                push_bias = 50;
            repeat (burst_len) begin
                if ($urandom_range(99) < push_bias)
                    kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
                else
                    kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_REAR;
                send_item(kind, pick_value());
                sent++;
            end
            if ($urandom_range(3) == 0)
                wait_for_drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pops();
        test_both_ends();
        wait_for_drain();
        test_random_bursts(11, 170);
        test_random_bursts(81, 160);
        test_random_bursts(0, 170);

        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge i_clk);

        $display("%0d requests: %0d pushes stored, %0d pops returned a value,",
                 accepted_items, n_pushes, n_pops);
        $display("%0d pushes refused while full, %0d pops refused while empty",
                 n_full, n_empty);
        if (error_count == 0)
            $display("double_ended_queue_test: done, clean");
        else
            $display("double_ended_queue_test: done, errors");
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("double_ended_queue_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
